// ===== design/char_lcd_number_formatter_assert.svh =====
// Assertion macros used by the checker file.
`ifndef CHAR_LCD_NUMBER_FORMATTER_ASSERT_SVH
`define CHAR_LCD_NUMBER_FORMATTER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CLNF_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("%m: check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CLNF_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("%m: check failed");

`endif

// ===== design/clnf_pkg.sv =====
`default_nettype none
package clnf_pkg;

    // Digit count limits
    localparam int MAX_DIGITS = 16;
    localparam int POS_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Request codes
    localparam logic [2:0] REQ_CHAR = 3'd0;
    localparam logic [2:0] REQ_UDEC = 3'd1;
    localparam logic [2:0] REQ_SDEC = 3'd2;
    localparam logic [2:0] REQ_HEX  = 3'd3;
    localparam logic [2:0] REQ_BIN  = 3'd4;

    // Display line code for the top line
    localparam logic [1:0] LINE_TOP = 2'd1;

    // Bus byte constants
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [6:0] LINE2_OFFSET = 7'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_A      = 8'h41;
    localparam logic [7:0] ASCII_PLUS   = 8'h2B;
    localparam logic [7:0] ASCII_MINUS  = 8'h2D;

    // Divide by ten: q = (n * 52429) >> 19, exact for 16-bit n
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_SIGN,
        ST_DATA
    } t_state;

    // Format control handed to the character generator
    typedef struct packed {
        logic [2:0] req;
        logic       neg;
    } t_fmt_ctl;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = ASCII_ZERO + {4'b0, d};
        end else begin
            c = ASCII_A + {4'b0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/clnf_div10.sv =====
`default_nettype none
module clnf_div10
    import clnf_pkg::*;
(
    input  wire logic [15:0] i_mag,
    output logic      [15:0] o_quot,
    output logic      [3:0]  o_rem
);

    logic [31:0] w_prod;
    logic [15:0] w_times10;

    // Reciprocal multiply, then remainder by shift-add back-multiply
    assign w_prod    = 32'(i_mag) * 32'(DIV10_MUL);
    assign o_quot    = 16'(w_prod >> DIV10_SHIFT);
    assign w_times10 = (o_quot << 3) + (o_quot << 1);
    assign o_rem     = 4'(i_mag - w_times10);

endmodule
`default_nettype wire

// ===== design/clnf_char_gen.sv =====
`default_nettype none
module clnf_char_gen
    import clnf_pkg::*;
(
    input  wire t_fmt_ctl         i_ctl,
    input  wire logic [IDX_W-1:0] i_pos,
    input  wire logic [15:0]      i_value,
    input  wire logic [3:0]       i_dec_digit,
    output logic      [7:0]       o_data_byte,
    output logic      [7:0]       o_sign_byte
);

    logic [3:0] w_nib;
    logic       w_bit;

    // Hex nibble and binary bit at the current position; zero above the value
    always_comb begin
        w_nib = 4'd0;
        w_bit = 1'b0;
        if (32'(i_pos) < 4) begin
            w_nib = i_value[{2'(i_pos), 2'b00} +: 4];
        end
        if (32'(i_pos) < 16) begin
            w_bit = i_value[4'(i_pos)];
        end
    end

    // Data byte by request type
    always_comb begin
        case (i_ctl.req)
            REQ_CHAR:           o_data_byte = i_value[7:0];
            REQ_UDEC, REQ_SDEC: o_data_byte = ASCII_ZERO + {4'b0, i_dec_digit};
            REQ_HEX:            o_data_byte = hex_char(w_nib);
            REQ_BIN:            o_data_byte = ASCII_ZERO + {7'b0, w_bit};
            default:            o_data_byte = ASCII_ZERO;
        endcase
    end

    assign o_sign_byte = i_ctl.neg ? ASCII_MINUS : ASCII_PLUS;

endmodule
`default_nettype wire

// ===== design/char_lcd_number_formatter.sv =====
// Character display number writer.
// Input channel (i_in_valid / o_in_ready): one request per transaction with
// mode, line, column, 16-bit value and digit count. Output channel
// (o_out_valid / i_out_ready): a stream of bus bytes, the first a
// set-address command (o_is_data low), then data bytes; o_last marks the
// final byte of a request.
// A request is handled alone: o_in_ready is high only while the sequencer
// is idle. Decimal requests first run the shared divide-by-ten unit once
// per digit (at most 16 digits), then all modes emit one byte per cycle
// while the receiver is ready: 1 address byte plus up to 17 data bytes.
// The address byte is registered from the ADDR state, which decimal
// requests reach through the DIV state. The output register lets the
// next request be taken while the final byte still waits. A stalled
// receiver holds the byte and freezes the ADDR, SIGN and DATA states;
// the DIV state does not wait on it. Reset (synchronous, active low)
// returns the sequencer to idle and drops o_out_valid; no clearing pass
// is needed.
`default_nettype none
module char_lcd_number_formatter
    import clnf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [1:0]  i_line,
    input  wire logic [5:0]  i_column,
    input  wire logic [15:0] i_value,
    input  wire logic [4:0]  i_digit_count,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_is_data,
    output logic      [7:0]  o_bus_byte,
    output logic             o_last
);

    t_state           r_state, n_state;
    logic [2:0]       r_req, n_req;
    logic [6:0]       r_addr, n_addr;
    logic [15:0]      r_value, n_value;
    logic [15:0]      r_mag, n_mag;
    logic             r_neg, n_neg;
    logic [POS_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [3:0]       r_digs [MAX_DIGITS];
    logic             r_out_valid, n_out_valid;
    logic             r_out_is_data, n_out_is_data;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;

    logic             w_in_acc;
    logic             w_load;
    logic             w_is_num;
    logic             w_cnt_zero;
    logic             w_div_done;
    logic [POS_W-1:0] w_cnt_sat;
    logic [15:0]      w_quot;
    logic [3:0]       w_rem;
    logic [IDX_W-1:0] w_pos;
    t_fmt_ctl         w_ctl;
    logic [7:0]       w_data_byte;
    logic [7:0]       w_sign_byte;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_load     = !r_out_valid || i_out_ready;
    assign w_is_num   = (r_req == REQ_UDEC) || (r_req == REQ_SDEC) ||
                        (r_req == REQ_HEX)  || (r_req == REQ_BIN);
    assign w_cnt_zero = (r_cnt == '0);
    assign w_div_done = (32'(r_idx) == 32'(r_cnt) - 1);
    assign w_pos      = IDX_W'(r_pos - POS_W'(1));
    assign w_cnt_sat  = (32'(i_digit_count) > MAX_DIGITS) ? POS_W'(MAX_DIGITS)
                                                         : POS_W'(i_digit_count);

    // Shared divide-by-ten step
    clnf_div10 u_div10 (
        .i_mag  (r_mag),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    // Character generation for the current position
    assign w_ctl.req = r_req;
    assign w_ctl.neg = r_neg;

    clnf_char_gen u_char_gen (
        .i_ctl       (w_ctl),
        .i_pos       (w_pos),
        .i_value     (r_value),
        .i_dec_digit (r_digs[w_pos]),
        .o_data_byte (w_data_byte),
        .o_sign_byte (w_sign_byte)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if ((i_req_type == REQ_UDEC || i_req_type == REQ_SDEC) &&
                        w_cnt_sat != '0) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_ADDR;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                if (w_load) begin
                    if (r_req == REQ_SDEC) begin
                        n_state = ST_SIGN;
                    end else if (r_req == REQ_CHAR || (w_is_num && !w_cnt_zero)) begin
                        n_state = ST_DATA;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SIGN: begin
                if (w_load) begin
                    n_state = w_cnt_zero ? ST_IDLE : ST_DATA;
                end
            end
            ST_DATA: begin
                if (w_load && (r_req == REQ_CHAR || r_pos == POS_W'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and output byte
    always_comb begin
        n_req         = r_req;
        n_addr        = r_addr;
        n_value       = r_value;
        n_mag         = r_mag;
        n_neg         = r_neg;
        n_cnt         = r_cnt;
        n_pos         = r_pos;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_is_data = r_out_is_data;
        n_out_byte    = r_out_byte;
        n_out_last    = r_out_last;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_req   = i_req_type;
                    n_addr  = 7'({1'b0, i_column}) + 7'h7F +
                              ((i_line == LINE_TOP) ? 7'h00 : LINE2_OFFSET);
                    n_value = i_value;
                    n_neg   = (i_req_type == REQ_SDEC) && i_value[15];
                    n_mag   = n_neg ? (~i_value + 16'd1) : i_value;
                    n_cnt   = w_cnt_sat;
                    n_pos   = w_cnt_sat;
                    n_idx   = '0;
                end
            end
            ST_DIV: begin
                n_mag = w_quot;
                n_idx = r_idx + IDX_W'(1);
            end
            ST_ADDR: begin
                if (w_load) begin
                    n_out_valid   = 1'b1;
                    n_out_is_data = 1'b0;
                    n_out_byte    = CMD_SET_ADDR | {1'b0, r_addr};
                    n_out_last    = !(r_req == REQ_CHAR || r_req == REQ_SDEC ||
                                      (w_is_num && !w_cnt_zero));
                end
            end
            ST_SIGN: begin
                if (w_load) begin
                    n_out_valid   = 1'b1;
                    n_out_is_data = 1'b1;
                    n_out_byte    = w_sign_byte;
                    n_out_last    = w_cnt_zero;
                end
            end
            ST_DATA: begin
                if (w_load) begin
                    n_out_valid   = 1'b1;
                    n_out_is_data = 1'b1;
                    n_out_byte    = w_data_byte;
                    n_out_last    = (r_req == REQ_CHAR) || (r_pos == POS_W'(1));
                    n_pos         = r_pos - POS_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_addr        <= n_addr;
        r_value       <= n_value;
        r_mag         <= n_mag;
        r_neg         <= n_neg;
        r_cnt         <= n_cnt;
        r_pos         <= n_pos;
        r_idx         <= n_idx;
        r_out_is_data <= n_out_is_data;
        r_out_byte    <= n_out_byte;
        r_out_last    <= n_out_last;
    end

    // Decimal digit buffer, least significant first
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV) begin
            r_digs[r_idx] <= w_rem;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_data   = r_out_is_data;
    assign o_bus_byte  = r_out_byte;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

// ===== design/clnf_checker.sv =====
`default_nettype none
`include "char_lcd_number_formatter_assert.svh"
module clnf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [2:0]  i_req_type,
    input wire logic [1:0]  i_line,
    input wire logic [5:0]  i_column,
    input wire logic [15:0] i_value,
    input wire logic [4:0]  i_digit_count,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_is_data,
    input wire logic [7:0]  o_bus_byte,
    input wire logic        o_last
);

    logic r_first;
    logic w_in_acc;
    logic w_out_acc;
    logic w_in_unused;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign w_in_unused = ^{i_req_type, i_line, i_column, i_value, i_digit_count};

    // Next output byte opens a request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (w_out_acc) begin
            r_first <= o_last;
        end
    end

    // Stalled byte holds
    `CLNF_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_bus_byte) && $stable(o_is_data) && $stable(o_last))
    // Busy right after a request is taken
    `CLNF_ASSERT_NXT(a_busy_after_acc, w_in_acc && !w_in_unused || w_in_acc, !o_in_ready)
    // No new request while bytes of the current one remain
    `CLNF_ASSERT_IMP(a_no_acc_mid_req, o_out_valid && !o_last, !o_in_ready)
    // Each request opens with a command byte, data follows
    `CLNF_ASSERT_IMP(a_cmd_first, o_out_valid, o_is_data == !r_first)

endmodule

bind char_lcd_number_formatter clnf_checker u_clnf_checker (.*);
`default_nettype wire

// ===== verif/tb_char_lcd_number_formatter.sv =====
`timescale 1ns / 1ps
module tb_char_lcd_number_formatter;
    import clnf_pkg::*;

    localparam logic [1:0] LINE_BOTTOM   = 2'd2;
    localparam int         RANDOM_REQS   = 100;
    localparam int         TAIL_REQS     = 20;
    localparam int         DRAIN_CYCLES  = 40;
    localparam int         WATCHDOG_MAX  = 2000;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  line;
        logic [5:0]  column;
        logic [15:0] value;
        logic [4:0]  digit_count;
    } t_lcd_req;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } t_lcd_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_req_type = '0;
    logic [1:0]  i_line = '0;
    logic [5:0]  i_column = '0;
    logic [15:0] i_value = '0;
    logic [4:0]  i_digit_count = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_is_data;
    logic [7:0]  o_bus_byte;
    logic        o_last;

    t_lcd_req    pending_reqs [$];
    t_lcd_byte   expected_bytes [$];
    int          total_reqs = 0;
    int          reqs_accepted = 0;
    int          error_count = 0;
    int          idle_pct = 25;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          holds_done = 0;
    logic        in_tail;

    // no idling once the last few requests are going through
    assign in_tail = (reqs_accepted + TAIL_REQS >= total_reqs);

    char_lcd_number_formatter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_line        (i_line),
        .i_column      (i_column),
        .i_value       (i_value),
        .i_digit_count (i_digit_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_is_data     (o_is_data),
        .o_bus_byte    (o_bus_byte),
        .o_last        (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] bus byte check: %s", $time, what);
    endtask

    // Byte stream of one request: address command, then sign/digits/char
    function automatic void predict_bus_bytes(input t_lcd_req r);
        t_lcd_byte   seq [$];
        t_lcd_byte   tail;
        logic [3:0]  digs [MAX_DIGITS];
        logic [6:0]  addr;
        logic [15:0] mag;
        logic [3:0]  nib;
        int          n;
        n = (int'(r.digit_count) > MAX_DIGITS) ? MAX_DIGITS : int'(r.digit_count);
        // 7-bit address wraps, so column 0 lands on the last cell
        addr = {1'b0, r.column} + 7'h7F + ((r.line == LINE_TOP) ? 7'h00 : LINE2_OFFSET);
        seq.push_back('{1'b0, CMD_SET_ADDR | {1'b0, addr}, 1'b0});
        case (r.req_type)
            REQ_CHAR: begin
                seq.push_back('{1'b1, r.value[7:0], 1'b0});
            end
            REQ_UDEC, REQ_SDEC: begin
                mag = r.value;
                if (r.req_type == REQ_SDEC) begin
                    if (r.value[15]) begin
                        mag = ~r.value + 16'd1;
                        seq.push_back('{1'b1, ASCII_MINUS, 1'b0});
                    end else begin
                        seq.push_back('{1'b1, ASCII_PLUS, 1'b0});
                    end
                end
                for (int i = 0; i < n; i++) begin
                    digs[i] = 4'(mag % 16'd10);
                    mag = mag / 16'd10;
                end
                for (int i = n - 1; i >= 0; i--) begin
                    seq.push_back('{1'b1, ASCII_ZERO + {4'b0, digs[i]}, 1'b0});
                end
            end
            REQ_HEX: begin
                for (int p = n - 1; p >= 0; p--) begin
                    nib = (p < 4) ? 4'(r.value >> (4 * p)) : 4'd0;
                    seq.push_back('{1'b1, (nib < 4'd10) ? ASCII_ZERO + {4'b0, nib}
                                                        : ASCII_A + {4'b0, nib} - 8'd10, 1'b0});
                end
            end
            REQ_BIN: begin
                for (int p = n - 1; p >= 0; p--) begin
                    seq.push_back('{1'b1, ASCII_ZERO + {7'b0, (p < 16) ? r.value[p] : 1'b0},
                                    1'b0});
                end
            end
            default: begin
            end
        endcase
        tail = seq.pop_back();
        tail.last = 1'b1;
        seq.push_back(tail);
        foreach (seq[k]) expected_bytes.push_back(seq[k]);
    endfunction

    // Request driver: one request per transaction, random gaps
    always @(posedge i_clk) begin : req_driver
        t_lcd_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!in_tail && $urandom_range(0, 99) < idle_pct) begin
                gap_left = $urandom_range(1, 11) - 1;
                i_in_valid <= 1'b0;
            end else begin
                nxt = pending_reqs.pop_front();
                i_req_type    <= nxt.req_type;
                i_line        <= nxt.line;
                i_column      <= nxt.column;
                i_value       <= nxt.value;
                i_digit_count <= nxt.digit_count;
                i_in_valid    <= 1'b1;
                // change the idling mix now and then, including none at all
                if ($urandom_range(0, 15) == 0) begin
                    case ($urandom_range(0, 3))
                        0, 1:    idle_pct <= 0;
                        2:       idle_pct <= 20;
                        default: idle_pct <= 50;
                    endcase
                end
            end
        end
    end

    // Byte sink: random stall bursts plus two long hold-offs
    always @(posedge i_clk) begin : byte_sink
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (holds_done < 2 && reqs_accepted >= 8 + 62 * holds_done) begin
            // long hold so the block backs up and stalls its input
            hold_left = $urandom_range(60, 120) - 1;
            holds_done++;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!in_tail && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 11) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: check bytes out, predict on requests in, watchdog
    always @(posedge i_clk) begin : bus_monitor
        t_lcd_byte want;
        int        quiet_cycles;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte is_data=%0b byte=%02h last=%0b",
                                              o_is_data, o_bus_byte, o_last));
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_is_data !== want.is_data)
                        report_mismatch($sformatf("is_data %0b, want %0b",
                                                  o_is_data, want.is_data));
                    if (o_bus_byte !== want.bus_byte)
                        report_mismatch($sformatf("bus_byte %02h, want %02h",
                                                  o_bus_byte, want.bus_byte));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                                  o_last, want.last, want.bus_byte));
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_bus_bytes('{i_req_type, i_line, i_column, i_value, i_digit_count});
                reqs_accepted <= reqs_accepted + 1;
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        t_lcd_req q;
        // directed: every mode, field extremes, address wrap, saturation
        pending_reqs.push_back('{REQ_CHAR, LINE_TOP, 6'd1, 16'h0041, 5'd0});
        pending_reqs.push_back('{REQ_CHAR, LINE_BOTTOM, 6'd40, 16'hFFFF, 5'd31});
        pending_reqs.push_back('{REQ_UDEC, LINE_TOP, 6'd16, 16'd0, 5'd5});
        pending_reqs.push_back('{REQ_UDEC, LINE_BOTTOM, 6'd2, 16'hFFFF, 5'd5});
        pending_reqs.push_back('{REQ_UDEC, LINE_TOP, 6'd3, 16'hFFFF, 5'd16});
        pending_reqs.push_back('{REQ_UDEC, LINE_TOP, 6'd4, 16'd1234, 5'd0});
        pending_reqs.push_back('{REQ_UDEC, LINE_BOTTOM, 6'd5, 16'd54321, 5'd31});
        pending_reqs.push_back('{REQ_SDEC, LINE_TOP, 6'd6, 16'h8000, 5'd5});
        pending_reqs.push_back('{REQ_SDEC, LINE_BOTTOM, 6'd7, 16'h7FFF, 5'd5});
        pending_reqs.push_back('{REQ_SDEC, LINE_TOP, 6'd8, 16'hFFFF, 5'd3});
        pending_reqs.push_back('{REQ_SDEC, LINE_BOTTOM, 6'd9, 16'h8001, 5'd0});
        pending_reqs.push_back('{REQ_SDEC, LINE_TOP, 6'd10, 16'h0000, 5'd17});
        pending_reqs.push_back('{REQ_HEX, LINE_TOP, 6'd11, 16'hABCD, 5'd4});
        pending_reqs.push_back('{REQ_HEX, LINE_BOTTOM, 6'd12, 16'h1234, 5'd8});
        pending_reqs.push_back('{REQ_HEX, LINE_TOP, 6'd13, 16'hF0E9, 5'd31});
        pending_reqs.push_back('{REQ_BIN, LINE_BOTTOM, 6'd14, 16'hA5C3, 5'd16});
        pending_reqs.push_back('{REQ_BIN, LINE_TOP, 6'd15, 16'hFFFF, 5'd20});
        pending_reqs.push_back('{REQ_BIN, LINE_BOTTOM, 6'd33, 16'h0001, 5'd1});
        for (int c = int'(REQ_BIN) + 1; c < 8; c++) begin
            pending_reqs.push_back('{3'(c), LINE_TOP, 6'd20, 16'h5A5A, 5'd4});
        end
        pending_reqs.push_back('{REQ_UDEC, LINE_TOP, 6'd0, 16'd7, 5'd2});
        pending_reqs.push_back('{REQ_HEX, 2'd0, 6'd0, 16'h00FF, 5'd2});
        pending_reqs.push_back('{REQ_CHAR, 2'd3, 6'd63, 16'h5A2A, 5'd0});

        // random: mostly well-formed requests, some raw bit noise
        for (int k = 0; k < RANDOM_REQS; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                q.req_type    = 3'($urandom);
                q.line        = 2'($urandom);
                q.column      = 6'($urandom);
                q.value       = 16'($urandom);
                q.digit_count = 5'($urandom);
            end else begin
                q.req_type = 3'($urandom_range(int'(REQ_CHAR), int'(REQ_BIN)));
                q.line     = ($urandom_range(0, 1) == 0) ? LINE_TOP : LINE_BOTTOM;
                q.column   = 6'($urandom_range(1, 40));
                case ($urandom_range(0, 3))
                    0:       q.value = 16'($urandom_range(0, 15));
                    1:       q.value = {1'b1, 15'($urandom)};
                    default: q.value = 16'($urandom);
                endcase
                if ($urandom_range(0, 7) == 0)
                    q.digit_count = 5'($urandom_range(0, MAX_DIGITS));
                else
                    q.digit_count = 5'($urandom_range(1, 6));
            end
            pending_reqs.push_back(q);
        end
        total_reqs = pending_reqs.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request taken and every byte seen
        while (!(pending_reqs.size() == 0 && !i_in_valid && expected_bytes.size() == 0))
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/clnf_pkg.sv
design/clnf_div10.sv
design/clnf_char_gen.sv
design/char_lcd_number_formatter.sv
design/clnf_checker.sv
verif/tb_char_lcd_number_formatter.sv
